// ===== sv/stv_pkg.sv =====
// Package for the sorted term-count vector: sizes, word types, cell types and states.
package stv_pkg;

	// Chain size and stored widths
	localparam int MAX_DISTINCT = 64;
	localparam int INDEX_BITS   = 24;
	localparam int COUNT_BITS   = 16;

	// Fixed port field widths
	localparam int WORD_INDEX_W  = 24;
	localparam int ENTRY_COUNT_W = 16;

	// One input word
	typedef struct packed {
		logic [WORD_INDEX_W-1:0] word_index;
		logic                    word_kept;
		logic                    doc_end;
	} in_word_t;

	// One result word
	typedef struct packed {
		logic [WORD_INDEX_W-1:0]  entry_index;
		logic [ENTRY_COUNT_W-1:0] entry_count;
		logic                     entry_last;
		logic                     doc_empty;
		logic                     list_overflow;
	} out_word_t;

	// Contents of one cell
	typedef struct packed {
		logic                  used;
		logic [INDEX_BITS-1:0] word;
		logic [COUNT_BITS-1:0] count;
	} cell_t;

	// Control broadcast to every cell
	typedef struct packed {
		logic                  count_op;  // a kept word is being counted
		logic                  hit;       // some cell already holds the word
		logic                  full;      // last cell in use
		logic                  shift_out; // drain: every cell takes its right neighbour
		logic [INDEX_BITS-1:0] word;
	} cell_ctrl_t;

	typedef enum logic {
		ST_COUNT,
		ST_DRAIN
	} stv_state_t;

endpackage

// ===== sv/stv_cell.sv =====
// One cell of the chain: holds an index and its count, inserts, counts and shifts.
module stv_cell
	import stv_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  cell_ctrl_t ctrl,
	input  logic       prev_lt,
	input  cell_t      prev_cell,
	input  cell_t      next_cell,
	output cell_t      cell_q,
	output logic       lt,
	output logic       eq
);

	logic ins_here;
	logic ins_move;
	logic inc;

	// Compare against the broadcast index
	assign lt = cell_q.used && (cell_q.word < ctrl.word);
	assign eq = cell_q.used && (cell_q.word == ctrl.word);

	// New index lands here, or everything from the insert point moves right
	assign ins_here = ctrl.count_op && !ctrl.hit && !ctrl.full && !lt && prev_lt;
	assign ins_move = ctrl.count_op && !ctrl.hit && !ctrl.full && !lt && !prev_lt;
	assign inc      = ctrl.count_op && eq && (cell_q.count != {COUNT_BITS{1'b1}});

	// Occupancy flag, index and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_q <= '0;
		end else if (ctrl.shift_out) begin
			cell_q <= next_cell;
		end else if (ins_here) begin
			cell_q.used  <= 1'b1;
			cell_q.word  <= ctrl.word;
			cell_q.count <= COUNT_BITS'(1);
		end else if (ins_move) begin
			cell_q <= prev_cell;
		end else if (inc) begin
			cell_q.count <= cell_q.count + COUNT_BITS'(1);
		end
	end

endmodule

// ===== sv/sorted_term_count_vector_unit.sv =====
// Top level: sorted term-count vector built from a chain of counting cells.
//
//  channel | valid       | stall       | payload
//  --------+-------------+-------------+----------------------
//  words   | word_valid  | word_stall  | word_data (in_word_t)
//  entries | entry_valid | entry_stall | entry_data (out_word_t)
//
// Words are taken one per cycle unless stalled; each is registered, then counted
// or inserted across all cells in the following cycle (one broadcast compare each).
// A word with doc_end starts the drain: cells shift toward cell 0, one entry per
// cycle, so a document with n distinct indices gives n entries (1 if empty).
// word_stall is high from the doc_end word until the last entry is loaded.
// A stalled entry holds the drain; reset empties every cell at once.
module sorted_term_count_vector_unit
	import stv_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      word_valid,
	output logic      word_stall,
	input  in_word_t  word_data,
	output logic      entry_valid,
	input  logic      entry_stall,
	output out_word_t entry_data
);

	stv_state_t state_q, state_d;

	logic       valid_s1;
	in_word_t   word_s1;
	logic       overflow_q;
	logic       overflow_set;
	logic       overflow_clr;
	logic       word_acc;
	logic       out_load;
	logic       out_last;
	out_word_t  out_d;
	cell_ctrl_t ctrl;

	cell_t                   cells  [MAX_DISTINCT];
	logic [MAX_DISTINCT-1:0] lt_vec;
	logic [MAX_DISTINCT-1:0] eq_vec;
	logic [MAX_DISTINCT-1:0] used_vec;

	// Input side
	assign word_stall = (state_q == ST_DRAIN) || (valid_s1 && word_s1.doc_end);
	assign word_acc   = word_valid && !word_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= word_acc;
		end
	end

	always_ff @(posedge clk) begin
		if (word_acc) begin
			word_s1 <= word_data;
		end
	end

	// Broadcast control
	always_comb begin
		ctrl.count_op  = valid_s1 && word_s1.word_kept;
		ctrl.hit       = |eq_vec;
		ctrl.full      = cells[MAX_DISTINCT-1].used;
		ctrl.shift_out = out_load && cells[0].used;
		ctrl.word      = word_s1.word_index[INDEX_BITS-1:0];
	end

	// Chain of cells
	for (genvar i = 0; i < MAX_DISTINCT; i++) begin : g_cell
		logic  prev_lt;
		cell_t prev_cell;
		cell_t next_cell;

		if (i == 0) begin : g_first
			assign prev_lt   = 1'b1;
			assign prev_cell = '0;
		end else begin : g_mid
			assign prev_lt   = lt_vec[i-1];
			assign prev_cell = cells[i-1];
		end

		if (i == MAX_DISTINCT - 1) begin : g_last
			assign next_cell = '0;
		end else begin : g_next
			assign next_cell = cells[i+1];
		end

		stv_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctrl     (ctrl),
			.prev_lt  (prev_lt),
			.prev_cell(prev_cell),
			.next_cell(next_cell),
			.cell_q   (cells[i]),
			.lt       (lt_vec[i]),
			.eq       (eq_vec[i])
		);

		assign used_vec[i] = cells[i].used;
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_COUNT;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and drain outputs
	always_comb begin
		state_d      = state_q;
		out_load     = 1'b0;
		out_last     = 1'b0;
		out_d        = '0;
		overflow_clr = 1'b0;
		case (state_q)
			ST_COUNT: begin
				if (valid_s1 && word_s1.doc_end) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				out_load = !entry_valid || !entry_stall;
				if (cells[0].used) begin
					out_last            = !cells[1].used;
					out_d.entry_index   = WORD_INDEX_W'(cells[0].word);
					out_d.entry_count   = ENTRY_COUNT_W'(cells[0].count);
					out_d.entry_last    = out_last;
					out_d.list_overflow = overflow_q;
				end else begin
					// empty document
					out_last         = 1'b1;
					out_d.entry_last = 1'b1;
					out_d.doc_empty  = 1'b1;
				end
				if (out_load && out_last) begin
					state_d      = ST_COUNT;
					overflow_clr = 1'b1;
				end
			end
			default: begin
				state_d = ST_COUNT;
			end
		endcase
	end

	// Dropped-index flag
	assign overflow_set = ctrl.count_op && !ctrl.hit && ctrl.full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			overflow_q <= 1'b0;
		end else if (overflow_clr) begin
			overflow_q <= 1'b0;
		end else if (overflow_set) begin
			overflow_q <= 1'b1;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_valid <= 1'b0;
		end else if (out_load) begin
			entry_valid <= 1'b1;
		end else if (!entry_stall) begin
			entry_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			entry_data <= out_d;
		end
	end

	// Used cells stay a contiguous run from cell 0
	a_used_contig: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot({1'b0, used_vec} + (MAX_DISTINCT + 1)'(1)))
		else $error("used cells not contiguous");

	// At most one cell holds any index
	a_eq_unique: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(eq_vec))
		else $error("index held by more than one cell");

	// No word enters while draining
	a_no_word_in_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DRAIN) |-> !word_acc)
		else $error("word accepted during drain");

	// A new entry is only loaded by the drain
	a_entry_from_drain: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(entry_valid) |-> $past(state_q == ST_DRAIN))
		else $error("entry produced outside drain");

endmodule

// ===== sim/tb_sorted_term_count_vector_unit.sv =====
// Testbench for the sorted term-count vector: queued word driver, entry checker and predictor.
module tb_sorted_term_count_vector_unit;
	import stv_pkg::*;

	localparam int CYCLE_LIMIT  = 1000000;
	localparam int RANDOM_WORDS = 190;
	localparam int TAIL_ITEMS   = 30;   // no idling once this few words remain
	localparam int PRINT_CAP    = 100;

	localparam logic [COUNT_BITS-1:0] COUNT_TOP = '1;

	typedef struct {
		in_word_t word;
		bit       may_idle;
	} queued_word_t;

	logic      clk         = 1'b0;
	logic      arst_n      = 1'b0;
	logic      word_valid  = 1'b0;
	logic      word_stall;
	in_word_t  word_data   = '0;
	logic      entry_valid;
	logic      entry_stall = 1'b0;
	out_word_t entry_data;

	queued_word_t word_queue[$];
	queued_word_t next_word;
	out_word_t    entries_due[$];

	// Predicted chain contents for the current document
	logic [INDEX_BITS-1:0] tally_index[MAX_DISTINCT];
	logic [COUNT_BITS-1:0] tally_count[MAX_DISTINCT];
	int                    tally_used    = 0;
	bit                    tally_dropped = 1'b0;

	int word_gap    = 0;
	int stall_left  = 0;
	bit stall_calm  = 1'b0;
	int cycles      = 0;
	int mismatches  = 0;
	int words_taken = 0;
	int docs_closed = 0;
	int entries_ok  = 0;
	int empties     = 0;
	int overflowed  = 0;
	int max_count   = 0;

	sorted_term_count_vector_unit uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.word_valid  (word_valid),
		.word_stall  (word_stall),
		.word_data   (word_data),
		.entry_valid (entry_valid),
		.entry_stall (entry_stall),
		.entry_data  (entry_data)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	task automatic flag_mismatch(input string what);
		if (mismatches < PRINT_CAP)
			$display("mismatch at cycle %0d: %s", cycles, what);
		mismatches++;
	endtask

	task automatic queue_word(input logic [WORD_INDEX_W-1:0] index, input bit kept,
			input bit last, input bit may_idle);
		queued_word_t q;
		q.word.word_index = index;
		q.word.word_kept  = kept;
		q.word.doc_end    = last;
		q.may_idle        = may_idle;
		word_queue.push_back(q);
	endtask

	// Count one accepted word; on doc_end, emit the sorted vector and clear
	task automatic tally_word(input in_word_t w);
		logic [INDEX_BITS-1:0] idx;
		out_word_t e;
		int pos;
		idx = w.word_index[INDEX_BITS-1:0];
		words_taken++;
		if (w.word_kept) begin
			pos = 0;
			while (pos < tally_used && tally_index[pos] < idx)
				pos++;
			if (pos < tally_used && tally_index[pos] == idx) begin
				if (tally_count[pos] != COUNT_TOP)
					tally_count[pos]++;
			end else if (tally_used >= MAX_DISTINCT) begin
				tally_dropped = 1'b1;
			end else begin
				for (int k = tally_used; k > pos; k--) begin
					tally_index[k] = tally_index[k-1];
					tally_count[k] = tally_count[k-1];
				end
				tally_index[pos] = idx;
				tally_count[pos] = COUNT_BITS'(1);
				tally_used++;
			end
		end
		if (w.doc_end) begin
			docs_closed++;
			if (tally_used == 0) begin
				e = '0;
				e.entry_last = 1'b1;
				e.doc_empty  = 1'b1;
				entries_due.push_back(e);
			end else begin
				for (int i = 0; i < tally_used; i++) begin
					e = '0;
					e.entry_index   = WORD_INDEX_W'(tally_index[i]);
					e.entry_count   = ENTRY_COUNT_W'(tally_count[i]);
					e.entry_last    = (i == tally_used - 1);
					e.list_overflow = tally_dropped;
					entries_due.push_back(e);
				end
			end
			tally_used    = 0;
			tally_dropped = 1'b0;
		end
	endtask

	// Word driver: holds a stalled word, idles in bursts between words
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_valid <= 1'b0;
			word_data  <= '0;
			word_gap = 0;
		end else if (!word_valid || !word_stall) begin
			if (word_valid)
				tally_word(word_data);
			if (word_gap > 0) begin
				word_gap--;
				word_valid <= 1'b0;
			end else if (word_queue.size() > 0) begin
				next_word = word_queue.pop_front();
				word_data  <= next_word.word;
				word_valid <= 1'b1;
				if (next_word.may_idle && word_queue.size() > TAIL_ITEMS &&
						$urandom_range(0, 5) == 0)
					word_gap = $urandom_range(1, 12);
			end else begin
				word_valid <= 1'b0;
			end
		end
	end

	// Entry checker with random stall bursts
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_stall <= 1'b0;
			stall_left = 0;
		end else begin
			if (entry_valid && !entry_stall) begin
				if (entries_due.size() == 0) begin
					flag_mismatch($sformatf("unexpected entry %h", entry_data));
				end else begin
					out_word_t want;
					want = entries_due.pop_front();
					if (entry_data.entry_index !== want.entry_index)
						flag_mismatch($sformatf("entry_index got %h want %h",
							entry_data.entry_index, want.entry_index));
					if (entry_data.entry_count !== want.entry_count)
						flag_mismatch($sformatf("entry_count got %h want %h (index %h)",
							entry_data.entry_count, want.entry_count, want.entry_index));
					if (entry_data.entry_last !== want.entry_last)
						flag_mismatch($sformatf("entry_last got %b want %b (index %h)",
							entry_data.entry_last, want.entry_last, want.entry_index));
					if (entry_data.doc_empty !== want.doc_empty)
						flag_mismatch($sformatf("doc_empty got %b want %b",
							entry_data.doc_empty, want.doc_empty));
					if (entry_data.list_overflow !== want.list_overflow)
						flag_mismatch($sformatf("list_overflow got %b want %b",
							entry_data.list_overflow, want.list_overflow));
					entries_ok++;
					if (want.doc_empty)
						empties++;
					if (want.list_overflow)
						overflowed++;
					if (int'(want.entry_count) > max_count)
						max_count = int'(want.entry_count);
				end
			end
			if ($urandom_range(0, 31) == 0)
				stall_calm = ~stall_calm;
			if (stall_left > 0) begin
				stall_left--;
				entry_stall <= 1'b1;
			end else if (!stall_calm && word_queue.size() > TAIL_ITEMS &&
					$urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(1, 12) - 1;
				entry_stall <= 1'b1;
			end else begin
				entry_stall <= 1'b0;
			end
		end
	end

	// Run limit
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d entries outstanding", cycles,
				entries_due.size());
			$display("[sorted_term_count_vector_unit] ERROR");
			$finish;
		end
	end

	// Stimulus and end of run
	initial begin
		int queued;
		int len;
		int kind;
		int base;
		bit calm;

		// Directed: empty document ended by an ignored word
		queue_word(24'hABCDEF, 1'b0, 1'b1, 1'b1);
		// single word at the top of the index range
		queue_word(24'hFFFFFF, 1'b1, 1'b1, 1'b1);
		// extremes, repeats, ignored word in the middle and at the end
		queue_word(24'h000000, 1'b1, 1'b0, 1'b1);
		queue_word(24'hFFFFFF, 1'b1, 1'b0, 1'b1);
		queue_word(24'h000000, 1'b1, 1'b0, 1'b1);
		queue_word(24'h800000, 1'b1, 1'b0, 1'b1);
		queue_word(24'h7FFFFF, 1'b1, 1'b0, 1'b1);
		queue_word(24'h123456, 1'b0, 1'b0, 1'b1);
		queue_word(24'h800000, 1'b1, 1'b0, 1'b1);
		queue_word(24'h555555, 1'b0, 1'b1, 1'b1);
		// single word at index zero
		queue_word(24'h000000, 1'b1, 1'b1, 1'b1);
		// descending arrivals force insertion at the head
		queue_word(24'd30, 1'b1, 1'b0, 1'b1);
		queue_word(24'd20, 1'b1, 1'b0, 1'b1);
		queue_word(24'd10, 1'b1, 1'b0, 1'b1);
		queue_word(24'd20, 1'b1, 1'b0, 1'b1);
		queue_word(24'd10, 1'b1, 1'b0, 1'b1);
		queue_word(24'd5,  1'b1, 1'b1, 1'b1);
		// full list: every cell used, then new indices dropped, old ones still counted
		for (int i = 0; i < MAX_DISTINCT; i++)
			queue_word(WORD_INDEX_W'(((i * 37) % MAX_DISTINCT) * 3 + 5), 1'b1, 1'b0, 1'b1);
		queue_word(24'h000001, 1'b1, 1'b0, 1'b1);
		queue_word(24'hFFFFFF, 1'b1, 1'b0, 1'b1);
		queue_word(24'd5, 1'b1, 1'b0, 1'b1);
		queue_word(24'd8, 1'b1, 1'b1, 1'b1);

		// Random documents
		queued = 0;
		while (queued < RANDOM_WORDS) begin
			kind = $urandom_range(0, 19);
			calm = ($urandom_range(0, 3) == 0);
			base = $urandom_range(0, 24'hFFFFF8);
			if (kind == 0) begin
				// overflowing document
				len = MAX_DISTINCT + $urandom_range(1, 8);
				for (int i = 0; i < len; i++)
					queue_word(WORD_INDEX_W'($urandom_range(0, 24'hFFFFFF)), 1'b1,
						i == len - 1, !calm);
			end else if (kind < 3) begin
				// only ignored words
				len = $urandom_range(1, 4);
				for (int i = 0; i < len; i++)
					queue_word(WORD_INDEX_W'($urandom_range(0, 24'hFFFFFF)), 1'b0,
						i == len - 1, !calm);
			end else if (kind < 6) begin
				// scattered indices over the full range
				len = $urandom_range(1, 16);
				for (int i = 0; i < len; i++)
					queue_word(WORD_INDEX_W'($urandom_range(0, 24'hFFFFFF)),
						$urandom_range(0, 7) != 0, i == len - 1, !calm);
			end else begin
				// clustered indices, many repeats
				len = $urandom_range(1, 20);
				for (int i = 0; i < len; i++)
					queue_word(WORD_INDEX_W'(base + $urandom_range(0, 7)),
						$urandom_range(0, 7) != 0, i == len - 1, !calm);
			end
			queued += len;
		end

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		do @(posedge clk); while (word_queue.size() > 0 || word_valid);
		do @(posedge clk); while (entries_due.size() > 0);
		repeat (MAX_DISTINCT + 16) @(posedge clk);

		$display("%0d words in %0d documents, %0d entries checked in %0d cycles",
			words_taken, docs_closed, entries_ok, cycles);
		$display("%0d empty documents, %0d overflow entries, highest count %0d",
			empties, overflowed, max_count);
		if (mismatches == 0) begin
			$display("[sorted_term_count_vector_unit] OK");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("[sorted_term_count_vector_unit] ERROR");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
sv/stv_pkg.sv
sv/stv_cell.sv
sv/sorted_term_count_vector_unit.sv
sim/tb_sorted_term_count_vector_unit.sv
